[sv/wpa_pkg.sv]
// ----------------------------------------------------------------------------
// Waveform phase accumulator package
// Shared constants, register indexes, waveform codes, unit interface types
// and the cosine table generator.
// ----------------------------------------------------------------------------
package wpa_pkg;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int TRIG_TABLE_BITS_DEF = 10;

    localparam logic [47:0] PERIOD_MIN = 48'd4295;
    localparam logic [47:0] PERIOD_RST = 48'h0001_0000_0000;
    localparam logic [31:0] AMP_RST    = 32'h0001_0000;

    // configuration register indexes
    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_CENTER = 2'd1;
    localparam logic [1:0] REG_AMP    = 2'd2;
    localparam logic [1:0] REG_POFF   = 2'd3;

    // waveform codes; the fourth code is reserved and yields a zero waveform value
    localparam logic [1:0] WAVE_SINE = 2'd0;
    localparam logic [1:0] WAVE_TRI  = 2'd1;
    localparam logic [1:0] WAVE_SAW  = 2'd2;

    localparam longint Q30        = 64'sd1073741824;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;

    typedef struct packed {
        logic        start;
        logic [31:0] arg;       // fraction of a waveform period, LSB 2^-32 period
    } cos_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] y;  // Q30
    } cos_rsp_t;

    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [47:0] divisor;
    } div_req_t;

    // cos(idx / 2^tb * pi/2) in Q30, Taylor series evaluated at elaboration
    function automatic logic signed [31:0] cos_entry(input int tb, input int idx);
        longint x;
        longint x2;
        longint t;
        x  = (TWO_PI_Q30 * longint'(idx)) >>> (tb + 2);
        x2 = (x * x) >>> 30;
        t  = Q30;
        t  = Q30 - (x2 * t) / (182 * Q30);
        t  = Q30 - (x2 * t) / (132 * Q30);
        t  = Q30 - (x2 * t) / (90 * Q30);
        t  = Q30 - (x2 * t) / (56 * Q30);
        t  = Q30 - (x2 * t) / (30 * Q30);
        t  = Q30 - (x2 * t) / (12 * Q30);
        t  = Q30 - (x2 * t) / (2 * Q30);
        return t[31:0];
    endfunction

endpackage

[sv/wpa_cos_rom.sv]
// ----------------------------------------------------------------------------
// Quarter-wave cosine table
// Constant table of 2^TRIG_TABLE_BITS+1 Q30 entries with registered read.
// ----------------------------------------------------------------------------
module wpa_cos_rom #(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic                       clk,
    input  logic [TRIG_TABLE_BITS:0]   addr,
    output logic signed [31:0]         q
);
    import wpa_pkg::*;

    localparam int ENTRIES = (1 << TRIG_TABLE_BITS) + 1;

    logic signed [31:0] rom_w [ENTRIES];

    for (genvar i = 0; i < ENTRIES; i++) begin : g_rom
        localparam logic signed [31:0] VAL = cos_entry(TRIG_TABLE_BITS, i);
        assign rom_w[i] = VAL;
    end

    always_ff @(posedge clk)
    begin
        q <= rom_w[addr];
    end

endmodule

[sv/wpa_cos_unit.sv]
// ----------------------------------------------------------------------------
// Cosine unit
// cos(2 pi f) in Q30 for a 32-bit cycle fraction: quadrant fold, two table
// reads and one interpolation multiply.
// ----------------------------------------------------------------------------
module wpa_cos_unit #(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wpa_pkg::cos_req_t req,
    output wpa_pkg::cos_rsp_t rsp
);
    import wpa_pkg::*;

    localparam int                   SH   = 30 - TRIG_TABLE_BITS;
    localparam int                   PW   = 34 + SH;
    localparam logic [TRIG_TABLE_BITS:0] LAST = (TRIG_TABLE_BITS+1)'(1 << TRIG_TABLE_BITS);

    typedef enum logic [1:0] {C_IDLE, C_RDA, C_RDB, C_FIN} cstate_t;

    cstate_t                   state_reg;
    logic [TRIG_TABLE_BITS:0]  idx_reg;
    logic [SH-1:0]             fr_reg;
    logic                      neg_reg;
    logic signed [31:0]        a_reg;
    logic signed [PW-1:0]      prod_reg;
    logic                      done_reg;
    logic signed [31:0]        y_reg;

    logic [1:0]                quad_w;
    logic [30:0]               arg_w;
    logic [TRIG_TABLE_BITS:0]  idx_w;
    logic [TRIG_TABLE_BITS:0]  addr_w;
    logic signed [31:0]        rom_q;
    logic signed [32:0]        diff_w;
    logic signed [PW-1:0]      quo_w;
    logic signed [32:0]        val_w;
    logic signed [32:0]        yv_w;

    // fold to a quarter: r in quadrants 0 and 2, 1/4 - r in 1 and 3
    always_comb
    begin
        quad_w = req.arg[31:30];
        if (quad_w[0])
            arg_w = 31'h4000_0000 - {1'b0, req.arg[29:0]};
        else
            arg_w = {1'b0, req.arg[29:0]};
        idx_w = arg_w[30:SH];
    end

    assign addr_w = (state_reg == C_IDLE) ? idx_w :
                    ((idx_reg == LAST) ? idx_reg : idx_reg + 1'b1);

    wpa_cos_rom #(
        .TRIG_TABLE_BITS(TRIG_TABLE_BITS)
    ) u_rom (
        .clk (clk),
        .addr(addr_w),
        .q   (rom_q)
    );

    assign diff_w = {rom_q[31], rom_q} - {a_reg[31], a_reg};

    // interpolation divide truncates toward zero
    always_comb
    begin
        quo_w = prod_reg >>> SH;
        if (prod_reg[PW-1] && (prod_reg[SH-1:0] != '0))
            quo_w = quo_w + 1'b1;
        val_w = {a_reg[31], a_reg} + quo_w[32:0];
        yv_w  = neg_reg ? -val_w : val_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (req.start)
                    begin
                        idx_reg   <= idx_w;
                        fr_reg    <= arg_w[SH-1:0];
                        neg_reg   <= quad_w[0] ^ quad_w[1];
                        state_reg <= C_RDA;
                    end
                end
                C_RDA:
                begin
                    a_reg     <= rom_q;
                    state_reg <= C_RDB;
                end
                C_RDB:
                begin
                    prod_reg  <= PW'(diff_w) * PW'($signed({1'b0, fr_reg}));
                    state_reg <= C_FIN;
                end
                C_FIN:
                begin
                    y_reg     <= yv_w[31:0];
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.y    = y_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !rsp.done)
        else $error("cos unit done held longer than one cycle");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (req.start && state_reg == C_IDLE) |=> !rsp.done)
        else $error("cos unit finished in the cycle after start");

endmodule

[sv/wpa_divider.sv]
// ----------------------------------------------------------------------------
// Phase increment divider
// Restoring long division of dividend * 2^(PHASE_BITS+16) by divisor, one
// quotient bit per cycle; keeps the low PHASE_BITS quotient bits.
// ----------------------------------------------------------------------------
module wpa_divider #(
    parameter int PHASE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wpa_pkg::div_req_t     req,
    output logic                  done,
    output logic [PHASE_BITS-1:0] quotient
);
    import wpa_pkg::*;

    localparam int STEPS = 48 + PHASE_BITS + 16;
    localparam int CW    = $clog2(STEPS + 1);
    localparam logic [CW-1:0] LAST_STEP = CW'(STEPS - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CW-1:0]         cnt_reg;
    logic [47:0]           num_reg;
    logic [47:0]           rem_reg;
    logic [47:0]           den_reg;
    logic [PHASE_BITS-1:0] quo_reg;

    logic [48:0]           shifted_w;
    logic                  ge_w;
    logic [48:0]           diff_w;

    always_comb
    begin
        shifted_w = {rem_reg, num_reg[47]};
        ge_w      = shifted_w >= {1'b0, den_reg};
        diff_w    = shifted_w - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= req.dividend;
                rem_reg  <= '0;
                den_reg  <= req.divisor;
                quo_reg  <= '0;
            end
            else if (busy_reg)
            begin
                num_reg <= {num_reg[46:0], 1'b0};
                rem_reg <= ge_w ? diff_w[47:0] : shifted_w[47:0];
                quo_reg <= {quo_reg[PHASE_BITS-2:0], ge_w};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_start_gap: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> !done)
        else $error("divider done right after start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy_reg)
        else $error("divider done while still busy");

endmodule

[sv/waveform_phase_accumulator.sv]
// ----------------------------------------------------------------------------
// Waveform phase accumulator
// Oscillator that advances a cycle phase by elapsed time over the period,
// remaps the phase on a waveform change, and outputs a scaled, saturated
// sine, triangle or sawtooth sample.
//
//   channel   signals                                  direction
//   in        in_valid/in_ready, time_now, wave_select  input transfer
//   out       out_valid/out_ready, out_value            output transfer
//   cfg       cfg_write, cfg_index, cfg_data            register write
//
// One transfer in at a time; unless an item remaps to sine, most of it is spent
// in the bit-serial divider (PHASE_BITS+64 steps). A sine output adds one pass
// of the cosine unit; a remap from sine adds one more, and a remap to sine runs
// a 31-step arccos search on the cosine unit.
// Reset clears phase, history and registers to their defaults; no clearing
// pass. A stalled result waits in the output register; the next item is
// taken meanwhile and stops at its final step until the register frees.
// ----------------------------------------------------------------------------
module waveform_phase_accumulator #(
    parameter int PHASE_BITS      = wpa_pkg::PHASE_BITS_DEF,
    parameter int TRIG_TABLE_BITS = wpa_pkg::TRIG_TABLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [47:0] time_now,
    input  logic [1:0]         wave_select,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_value,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [47:0]        cfg_data
);
    import wpa_pkg::*;

    localparam int PB = PHASE_BITS;

    localparam logic signed [33:0] Q1_34 = 34'sd1073741824;
    localparam logic signed [33:0] Q2_34 = 34'sd2147483648;
    localparam logic signed [33:0] Q3_34 = 34'sd3221225472;
    localparam logic signed [34:0] Q1_35 = 35'sd1073741824;
    localparam logic signed [34:0] Q3_35 = 35'sd3221225472;
    localparam logic signed [63:0] HALF_LSB = 64'sd536870912;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_DIV, S_PHASE, S_REMAP, S_RCOS_W, S_ACOS, S_ACOS_W,
        S_ACOS_FIN, S_WAVE, S_WCOS_W, S_MUL, S_OUT
    } state_t;

    function automatic logic [31:0] to32(input logic [PB-1:0] p);
        logic [PB+31:0] e;
        e = {p, 32'b0} >> PB;
        return e[31:0];
    endfunction

    function automatic logic [PB-1:0] from32(input logic [31:0] f);
        logic [PB+31:0] e;
        e = {f, {PB{1'b0}}} >> 32;
        return e[PB-1:0];
    endfunction

    // configuration
    logic [47:0]        period_reg;
    logic signed [31:0] center_reg;
    logic signed [31:0] amp_reg;
    logic [31:0]        poff_reg;

    // oscillator state
    logic [PB-1:0]      phase_reg;
    logic signed [47:0] last_time_reg;
    logic [1:0]         last_wave_reg;
    logic               seen_reg;

    // working registers
    state_t             state_reg;
    logic signed [47:0] now_reg;
    logic [1:0]         sel_reg;
    logic               back_reg;
    logic [PB-1:0]      p_reg;
    logic [31:0]        acos_f_reg;
    logic [4:0]         bit_reg;
    logic signed [34:0] acos_y_reg;
    logic signed [31:0] w_reg;
    logic signed [63:0] prod_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_value_reg;
    logic               div_start_reg;
    logic [47:0]        div_num_reg;
    logic [47:0]        div_den_reg;
    logic               cos_start_reg;
    logic [31:0]        cos_arg_reg;

    div_req_t           div_req;
    logic               div_done;
    logic [PB-1:0]      div_quo;
    cos_req_t           cos_req;
    cos_rsp_t           cos_rsp;

    logic signed [48:0] dt_w;
    logic signed [48:0] mag_full_w;
    logic [47:0]        per_w;
    logic [31:0]        p32_w;
    logic               low_w;
    logic signed [33:0] nc_w;
    logic signed [33:0] r01_w;
    logic signed [33:0] r02_w;
    logic signed [34:0] y10_w;
    logic signed [34:0] y20_w;
    logic signed [34:0] cos_ys_w;
    logic [31:0]        cand_w;
    logic [PB-1:0]      t_w;
    logic [31:0]        t32_w;
    logic signed [33:0] wtri_w;
    logic signed [33:0] wsaw_w;
    logic signed [63:0] rnd_w;
    logic signed [35:0] res_w;
    logic signed [31:0] sat_w;

    always_comb
    begin
        dt_w       = {now_reg[47], now_reg} - {last_time_reg[47], last_time_reg};
        mag_full_w = dt_w[48] ? -dt_w : dt_w;
        per_w      = (period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg;

        p32_w = to32(p_reg);
        low_w = ~p_reg[PB-1];

        // remaps from sine: nc = -cos
        nc_w  = -{{2{cos_rsp.y[31]}}, cos_rsp.y};
        r01_w = low_w ? (nc_w + Q1_34) : (Q3_34 - nc_w);
        r02_w = (nc_w <<< 1) + Q2_34;

        // arccos targets for remaps to sine
        y10_w = low_w ? (Q1_35 - $signed({3'b0, p32_w}))
                      : ($signed({3'b0, p32_w}) - Q3_35);
        y20_w = Q1_35 - $signed({4'b0, p32_w[31:1]});

        cos_ys_w = {{3{cos_rsp.y[31]}}, cos_rsp.y};
        cand_w   = acos_f_reg | (32'd1 << bit_reg);

        t_w    = p_reg + from32(poff_reg);
        t32_w  = to32(t_w);
        wtri_w = ~t_w[PB-1] ? ($signed({2'b0, t32_w}) - Q1_34)
                            : (Q3_34 - $signed({2'b0, t32_w}));
        wsaw_w = $signed({3'b0, t32_w[31:1]}) - Q1_34;

        rnd_w = prod_reg + HALF_LSB;
        res_w = {{2{rnd_w[63]}}, rnd_w[63:30]} + {{4{center_reg[31]}}, center_reg};
        if (res_w > 36'sh0_7FFF_FFFF)
            sat_w = 32'sh7FFF_FFFF;
        else if (res_w < -36'sh0_8000_0000)
            sat_w = 32'sh8000_0000;
        else
            sat_w = res_w[31:0];
    end

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = div_num_reg;
    assign div_req.divisor  = div_den_reg;

    assign cos_req.start = cos_start_reg;
    assign cos_req.arg   = cos_arg_reg;

    wpa_divider #(
        .PHASE_BITS(PB)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .done    (div_done),
        .quotient(div_quo)
    );

    wpa_cos_unit #(
        .TRIG_TABLE_BITS(TRIG_TABLE_BITS)
    ) u_cos (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (cos_req),
        .rsp  (cos_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RST;
            center_reg    <= '0;
            amp_reg       <= AMP_RST;
            poff_reg      <= '0;
            phase_reg     <= '0;
            last_time_reg <= '0;
            last_wave_reg <= WAVE_SINE;
            seen_reg      <= 1'b0;
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
            cos_start_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_PERIOD: period_reg <= cfg_data;
                    REG_CENTER: center_reg <= cfg_data[31:0];
                    REG_AMP:    amp_reg    <= cfg_data[31:0];
                    REG_POFF:   poff_reg   <= cfg_data[31:0];
                    default:    ;
                endcase
            end

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
            cos_start_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        now_reg   <= time_now;
                        sel_reg   <= wave_select;
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    back_reg      <= dt_w[48];
                    div_num_reg   <= mag_full_w[47:0];
                    div_den_reg   <= per_w;
                    div_start_reg <= 1'b1;
                    state_reg     <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_PHASE;
                end
                S_PHASE:
                begin
                    p_reg         <= back_reg ? phase_reg - div_quo : phase_reg + div_quo;
                    last_time_reg <= now_reg;
                    state_reg     <= S_REMAP;
                end
                S_REMAP:
                begin
                    state_reg <= S_WAVE;
                    if (seen_reg && last_wave_reg != sel_reg)
                    begin
                        case ({last_wave_reg, sel_reg})
                            {WAVE_SINE, WAVE_TRI}, {WAVE_SINE, WAVE_SAW}:
                            begin
                                cos_arg_reg   <= p32_w;
                                cos_start_reg <= 1'b1;
                                state_reg     <= S_RCOS_W;
                            end
                            {WAVE_TRI, WAVE_SINE}:
                            begin
                                acos_y_reg <= y10_w;
                                acos_f_reg <= '0;
                                bit_reg    <= 5'd30;
                                state_reg  <= S_ACOS;
                            end
                            {WAVE_SAW, WAVE_SINE}:
                            begin
                                acos_y_reg <= y20_w;
                                acos_f_reg <= '0;
                                bit_reg    <= 5'd30;
                                state_reg  <= S_ACOS;
                            end
                            {WAVE_TRI, WAVE_SAW}:
                                p_reg <= low_w ? (p_reg << 1) : -(p_reg << 1);
                            {WAVE_SAW, WAVE_TRI}:
                                p_reg <= p_reg >> 1;
                            default: ;
                        endcase
                    end
                end
                S_RCOS_W:
                begin
                    if (cos_rsp.done)
                    begin
                        if (sel_reg == WAVE_TRI)
                            p_reg <= from32(r01_w[31:0]);
                        else
                            p_reg <= from32(r02_w[31:0]);
                        state_reg <= S_WAVE;
                    end
                end
                S_ACOS:
                begin
                    cos_arg_reg   <= cand_w;
                    cos_start_reg <= 1'b1;
                    state_reg     <= S_ACOS_W;
                end
                S_ACOS_W:
                begin
                    if (cos_rsp.done)
                    begin
                        if (cos_ys_w >= acos_y_reg)
                            acos_f_reg <= cos_arg_reg;
                        if (bit_reg == '0)
                            state_reg <= S_ACOS_FIN;
                        else
                        begin
                            bit_reg   <= bit_reg - 1'b1;
                            state_reg <= S_ACOS;
                        end
                    end
                end
                S_ACOS_FIN:
                begin
                    // upper half of the triangle maps to the mirrored angle
                    if (last_wave_reg == WAVE_TRI && !low_w)
                        p_reg <= from32(32'd0 - acos_f_reg);
                    else
                        p_reg <= from32(acos_f_reg);
                    state_reg <= S_WAVE;
                end
                S_WAVE:
                begin
                    phase_reg     <= p_reg;
                    last_wave_reg <= sel_reg;
                    seen_reg      <= 1'b1;
                    state_reg     <= S_MUL;
                    case (sel_reg)
                        WAVE_SINE:
                        begin
                            cos_arg_reg   <= t32_w;
                            cos_start_reg <= 1'b1;
                            state_reg     <= S_WCOS_W;
                        end
                        WAVE_TRI: w_reg <= wtri_w[31:0];
                        WAVE_SAW: w_reg <= wsaw_w[31:0];
                        default:  w_reg <= '0;
                    endcase
                end
                S_WCOS_W:
                begin
                    if (cos_rsp.done)
                    begin
                        w_reg     <= -cos_rsp.y;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= w_reg * amp_reg;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_value_reg <= sat_w;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in progress");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    a_history_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (seen_reg && last_wave_reg == sel_reg))
        else $error("waveform history not updated before output");

endmodule
